FILE: sv/pdll_pkg.sv
// Shared types and constants for the pooled doubly linked list engine.
// No dependencies; imported by the engine top level, its checker and the bench.
`default_nettype none
package pdll_pkg;

    localparam int LID_W     = 4;
    localparam int ITEM_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [3:0] {
        KIND_CREATE  = 4'd0,
        KIND_COUNT   = 4'd1,
        KIND_FIRST   = 4'd2,
        KIND_LAST    = 4'd3,
        KIND_NEXT    = 4'd4,
        KIND_PREV    = 4'd5,
        KIND_CURRENT = 4'd6,
        KIND_ADD     = 4'd7,
        KIND_INSERT  = 4'd8,
        KIND_APPEND  = 4'd9,
        KIND_PREPEND = 4'd10,
        KIND_REMOVE  = 4'd11,
        KIND_TRIM    = 4'd12,
        KIND_CONCAT  = 4'd13,
        KIND_FREE    = 4'd14
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_NONE      = 3'd1,
        STATUS_NODE_FULL = 3'd2,
        STATUS_LIST_FULL = 3'd3,
        STATUS_BAD       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        POS_ON     = 2'd0,
        POS_BEFORE = 2'd1,
        POS_PAST   = 2'd2
    } pos_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_ITEM,
        ST_NEIGH,
        ST_LINK,
        ST_FIX,
        ST_UNLINK,
        ST_CONCAT,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: sv/pooled_doubly_linked_list_engine_unit.sv
// Pooled doubly linked list engine: list table in flops, node pool in memories.
// Count, create and bad requests take the shortest path, add after the cursor the longest;
// free also walks the whole list; one request is in flight, set by node memory reads.
// Result waits in an output register; the next request is taken while it waits.
// Reset (rst_n low, asynchronous): all lists unused, both free pools full.
// Depends on pdll_pkg. LIST_COUNT 1..16, NODE_COUNT 2..255.
`default_nettype none
module pooled_doubly_linked_list_engine_unit
    import pdll_pkg::*;
#(
    parameter int NODE_COUNT = 128,
    parameter int LIST_COUNT = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // list_id[3:0], other_list_id[7:4], item[39:8]
    input  wire logic [LID_W-1:0]     s_tuser,  // kind[3:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // item_out[31:0], new_list_id[35:32],
                                                // count_out[43:36], zero fill
    output logic [STATUS_W-1:0]       m_tuser   // status[2:0]
);

    localparam int NW  = $clog2(NODE_COUNT + 1);
    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LW  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int LCW = $clog2(LIST_COUNT + 1);
    localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);

    // node pool
    logic [ITEM_W-1:0] node_item_mem [NODE_COUNT];
    logic [NW-1:0]     node_next_mem [NODE_COUNT];
    logic [NW-1:0]     node_prev_mem [NODE_COUNT];
    logic [AW-1:0]     stk_mem       [NODE_COUNT];

    logic              rd_en;
    logic [NW-1:0]     rd_ptr;
    logic [ITEM_W-1:0] rd_item;
    logic [NW-1:0]     rd_next;
    logic [NW-1:0]     rd_prev;

    logic              item_we;
    logic [NW-1:0]     item_wa;
    logic              next_we;
    logic [NW-1:0]     next_wa;
    logic [NW-1:0]     next_wd;
    logic              prev_we;
    logic [NW-1:0]     prev_wa;
    logic [NW-1:0]     prev_wd;
    logic              stk_we;
    logic [AW-1:0]     stk_top;

    // list table
    logic [NW-1:0]  head_reg   [LIST_COUNT];
    logic [NW-1:0]  head_next  [LIST_COUNT];
    logic [NW-1:0]  tail_reg   [LIST_COUNT];
    logic [NW-1:0]  tail_next  [LIST_COUNT];
    logic [NW-1:0]  cur_reg    [LIST_COUNT];
    logic [NW-1:0]  cur_next   [LIST_COUNT];
    pos_t           pos_reg    [LIST_COUNT];
    pos_t           pos_next   [LIST_COUNT];
    logic [NW-1:0]  size_reg   [LIST_COUNT];
    logic [NW-1:0]  size_next  [LIST_COUNT];
    logic           used_reg   [LIST_COUNT];
    logic           used_next  [LIST_COUNT];
    logic [LW-1:0]  fl_stack_reg  [LIST_COUNT];
    logic [LW-1:0]  fl_stack_next [LIST_COUNT];
    logic [LCW-1:0] fl_cnt_reg, fl_cnt_next;

    logic [NW-1:0] rc_cnt_reg, rc_cnt_next;
    logic [NW-1:0] fresh_reg, fresh_next;
    logic [NW-1:0] rc_dec;

    state_t state_reg, state_next;

    // request and work registers
    kind_t             kind_reg, kind_next;
    logic [LID_W-1:0]  lid_reg, lid_next;
    logic [LID_W-1:0]  mid_reg, mid_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    status_t           res_status_reg, res_status_next;
    logic [ITEM_W-1:0] res_item_reg, res_item_next;
    logic [LID_W-1:0]  res_new_reg, res_new_next;
    logic [NW-1:0]     a_reg, a_next;
    logic [NW-1:0]     b_reg, b_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     walk_cnt_reg, walk_cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ITEM_W-1:0]   out_item_reg, out_item_next;
    logic [LID_W-1:0]    out_new_reg, out_new_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // view of one list entry
    logic [LW-1:0] lix, mix, vix;
    logic [NW-1:0] v_head, v_tail, v_cur, v_size;
    pos_t          v_pos;
    logic          l_ok, m_bad, empty, node_full;
    logic          nx_fail, pv_fail, cur_fail, add_rd, ins_rd;
    logic [NW-1:0] alloc_n;

    logic          rel_en;
    logic [LW-1:0] rel_idx;
    logic          new_en;
    logic [LW-1:0] new_idx;

    assign lix    = lid_reg[LW-1:0];
    assign mix    = mid_reg[LW-1:0];
    assign vix    = (state_reg == ST_CONCAT) ? mix : lix;
    assign v_head = head_reg[vix];
    assign v_tail = tail_reg[vix];
    assign v_cur  = cur_reg[vix];
    assign v_pos  = pos_reg[vix];
    assign v_size = size_reg[vix];

    assign l_ok      = (lid_reg < LIST_COUNT) && used_reg[lix];
    assign m_bad     = (mid_reg >= LIST_COUNT) || (mid_reg == lid_reg) || !used_reg[mix];
    assign empty     = (v_size == '0);
    assign node_full = (rc_cnt_reg == '0) && (fresh_reg == NIL);
    assign rc_dec    = rc_cnt_reg - NW'(1);
    assign alloc_n   = (rc_cnt_reg != '0) ? NW'(stk_top) : fresh_reg;

    assign nx_fail  = empty || (v_pos == POS_PAST) || ((v_pos == POS_ON) && (v_cur == v_tail));
    assign pv_fail  = empty || (v_pos == POS_BEFORE) || ((v_pos == POS_ON) && (v_cur == v_head));
    assign cur_fail = empty || (v_pos != POS_ON);
    assign add_rd   = !empty && (kind_reg == KIND_ADD) && (v_pos == POS_ON) && (v_cur != v_tail);
    assign ins_rd   = !empty && (kind_reg == KIND_INSERT) && (v_pos == POS_ON)
                      && (v_cur != v_head);

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_item <= node_item_mem[rd_ptr[AW-1:0]];
            rd_next <= node_next_mem[rd_ptr[AW-1:0]];
            rd_prev <= node_prev_mem[rd_ptr[AW-1:0]];
        end
        if (item_we)
        begin
            node_item_mem[item_wa[AW-1:0]] <= item_reg;
        end
        if (next_we)
        begin
            node_next_mem[next_wa[AW-1:0]] <= next_wd;
        end
        if (prev_we)
        begin
            node_prev_mem[prev_wa[AW-1:0]] <= prev_wd;
        end
    end

    // recycled node stack: nodes not yet handed out come from fresh_reg
    always_ff @(posedge clk)
    begin
        stk_top <= stk_mem[rc_dec[AW-1:0]];
        if (stk_we)
        begin
            stk_mem[rc_cnt_reg[AW-1:0]] <= n_reg[AW-1:0];
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                if (kind_reg != KIND_CREATE && l_ok)
                begin
                    priority case (kind_reg)
                        KIND_FIRST, KIND_LAST:
                            state_next = empty ? ST_DONE : ST_ITEM;
                        KIND_NEXT:
                            state_next = nx_fail ? ST_DONE :
                                         (v_pos == POS_BEFORE) ? ST_ITEM : ST_STEP;
                        KIND_PREV:
                            state_next = pv_fail ? ST_DONE :
                                         (v_pos == POS_PAST) ? ST_ITEM : ST_STEP;
                        KIND_CURRENT:
                            state_next = cur_fail ? ST_DONE : ST_ITEM;
                        KIND_ADD, KIND_INSERT, KIND_APPEND, KIND_PREPEND:
                            state_next = (item_reg == '0 || node_full) ? ST_DONE :
                                         (add_rd || ins_rd) ? ST_NEIGH : ST_LINK;
                        KIND_REMOVE:
                            state_next = cur_fail ? ST_DONE : ST_UNLINK;
                        KIND_TRIM:
                            state_next = empty ? ST_DONE : ST_UNLINK;
                        KIND_CONCAT:
                            state_next = m_bad ? ST_DONE : ST_CONCAT;
                        KIND_FREE:
                            state_next = empty ? ST_DONE : ST_WALK;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_STEP:   state_next = ST_ITEM;
            ST_ITEM:   state_next = ST_DONE;
            ST_NEIGH:  state_next = ST_LINK;
            ST_LINK:   state_next = ST_FIX;
            ST_FIX:    state_next = ST_DONE;
            ST_UNLINK: state_next = ST_DONE;
            ST_CONCAT: state_next = ST_DONE;
            ST_WALK:
            begin
                if (walk_cnt_reg == NW'(1) || rd_next == NIL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        size_next      = size_reg;
        used_next      = used_reg;
        fl_stack_next  = fl_stack_reg;
        fl_cnt_next    = fl_cnt_reg;
        rc_cnt_next    = rc_cnt_reg;
        fresh_next     = fresh_reg;
        kind_next      = kind_reg;
        lid_next       = lid_reg;
        mid_next       = mid_reg;
        item_next      = item_reg;
        res_status_next = res_status_reg;
        res_item_next  = res_item_reg;
        res_new_next   = res_new_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        walk_cnt_next  = walk_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_item_next  = out_item_reg;
        out_new_next   = out_new_reg;
        out_count_next = out_count_reg;
        rd_en   = 1'b0;
        rd_ptr  = '0;
        item_we = 1'b0;
        item_wa = '0;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        stk_we  = 1'b0;
        rel_en  = 1'b0;
        rel_idx = lix;
        new_en  = 1'b0;
        new_idx = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next       = kind_t'(s_tuser);
                    lid_next        = s_tdata[3:0];
                    mid_next        = s_tdata[7:4];
                    item_next       = s_tdata[39:8];
                    res_status_next = STATUS_OK;
                    res_item_next   = '0;
                    res_new_next    = '0;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_CREATE)
                begin
                    if (fl_cnt_reg == '0)
                    begin
                        res_status_next = STATUS_LIST_FULL;
                    end
                    else
                    begin
                        new_en       = 1'b1;
                        new_idx      = fl_stack_reg[LW'(fl_cnt_reg - LCW'(1))];
                        fl_cnt_next  = fl_cnt_reg - LCW'(1);
                        res_new_next = LID_W'(new_idx);
                    end
                end
                else if (!l_ok)
                begin
                    res_status_next = STATUS_BAD;
                end
                else
                begin
                    priority case (kind_reg)
                        KIND_COUNT:
                        begin
                            res_status_next = STATUS_OK;
                        end
                        KIND_FIRST, KIND_LAST:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_NONE;
                            end
                            else
                            begin
                                cur_next[lix] = (kind_reg == KIND_FIRST) ? v_head : v_tail;
                                pos_next[lix] = POS_ON;
                                rd_en  = 1'b1;
                                rd_ptr = (kind_reg == KIND_FIRST) ? v_head : v_tail;
                            end
                        end
                        KIND_NEXT, KIND_PREV:
                        begin
                            if ((kind_reg == KIND_NEXT) ? nx_fail : pv_fail)
                            begin
                                cur_next[lix]   = NIL;
                                pos_next[lix]   = (kind_reg == KIND_NEXT) ? POS_PAST : POS_BEFORE;
                                res_status_next = STATUS_NONE;
                            end
                            else if (kind_reg == KIND_NEXT && v_pos == POS_BEFORE)
                            begin
                                cur_next[lix] = v_head;
                                pos_next[lix] = POS_ON;
                                rd_en  = 1'b1;
                                rd_ptr = v_head;
                            end
                            else if (kind_reg == KIND_PREV && v_pos == POS_PAST)
                            begin
                                cur_next[lix] = v_tail;
                                pos_next[lix] = POS_ON;
                                rd_en  = 1'b1;
                                rd_ptr = v_tail;
                            end
                            else
                            begin
                                rd_en  = 1'b1;
                                rd_ptr = v_cur;
                            end
                        end
                        KIND_CURRENT:
                        begin
                            if (cur_fail)
                            begin
                                res_status_next = STATUS_NONE;
                            end
                            else
                            begin
                                rd_en  = 1'b1;
                                rd_ptr = v_cur;
                            end
                        end
                        KIND_ADD, KIND_INSERT, KIND_APPEND, KIND_PREPEND:
                        begin
                            a_next = NIL;
                            b_next = NIL;
                            if (item_reg == '0)
                            begin
                                res_status_next = STATUS_BAD;
                            end
                            else if (node_full)
                            begin
                                res_status_next = STATUS_NODE_FULL;
                            end
                            else if (add_rd || ins_rd)
                            begin
                                rd_en  = 1'b1;
                                rd_ptr = v_cur;
                            end
                            else if (!empty)
                            begin
                                priority if (kind_reg == KIND_APPEND)
                                begin
                                    a_next = v_tail;
                                end
                                else if (kind_reg == KIND_PREPEND || v_pos == POS_BEFORE)
                                begin
                                    b_next = v_head;
                                end
                                else if (kind_reg == KIND_ADD || v_pos == POS_PAST)
                                begin
                                    a_next = v_tail;
                                end
                                else
                                begin
                                    // insert with the cursor on the head
                                    b_next = v_head;
                                end
                            end
                        end
                        KIND_REMOVE, KIND_TRIM:
                        begin
                            if ((kind_reg == KIND_REMOVE) ? cur_fail : empty)
                            begin
                                res_status_next = STATUS_NONE;
                            end
                            else
                            begin
                                n_next = (kind_reg == KIND_REMOVE) ? v_cur : v_tail;
                                rd_en  = 1'b1;
                                rd_ptr = (kind_reg == KIND_REMOVE) ? v_cur : v_tail;
                            end
                        end
                        KIND_CONCAT:
                        begin
                            if (m_bad)
                            begin
                                res_status_next = STATUS_BAD;
                            end
                            else
                            begin
                                // hold the destination tail and size for the next cycle
                                a_next        = v_tail;
                                walk_cnt_next = v_size;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (empty)
                            begin
                                rel_en = 1'b1;
                            end
                            else
                            begin
                                n_next        = v_head;
                                walk_cnt_next = v_size;
                                rd_en  = 1'b1;
                                rd_ptr = v_head;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_BAD;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                cur_next[lix] = (kind_reg == KIND_NEXT) ? rd_next : rd_prev;
                pos_next[lix] = POS_ON;
                rd_en  = 1'b1;
                rd_ptr = (kind_reg == KIND_NEXT) ? rd_next : rd_prev;
            end
            ST_ITEM:
            begin
                res_item_next = rd_item;
            end
            ST_NEIGH:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    a_next = v_cur;
                    b_next = rd_next;
                end
                else
                begin
                    a_next = rd_prev;
                    b_next = v_cur;
                end
            end
            ST_LINK:
            begin
                n_next = alloc_n;
                if (rc_cnt_reg != '0)
                begin
                    rc_cnt_next = rc_dec;
                end
                else
                begin
                    fresh_next = fresh_reg + NW'(1);
                end
                item_we = 1'b1;
                item_wa = alloc_n;
                next_we = 1'b1;
                next_wa = alloc_n;
                next_wd = b_reg;
                prev_we = 1'b1;
                prev_wa = alloc_n;
                prev_wd = a_reg;
                if (a_reg == NIL)
                begin
                    head_next[lix] = alloc_n;
                end
                if (b_reg == NIL)
                begin
                    tail_next[lix] = alloc_n;
                end
                cur_next[lix]  = alloc_n;
                pos_next[lix]  = POS_ON;
                size_next[lix] = size_reg[lix] + NW'(1);
            end
            ST_FIX:
            begin
                next_we = (a_reg != NIL);
                next_wa = a_reg;
                next_wd = n_reg;
                prev_we = (b_reg != NIL);
                prev_wa = b_reg;
                prev_wd = n_reg;
            end
            ST_UNLINK:
            begin
                res_item_next = rd_item;
                if (rd_prev == NIL)
                begin
                    head_next[lix] = rd_next;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = rd_prev;
                    next_wd = rd_next;
                end
                if (rd_next == NIL)
                begin
                    tail_next[lix] = rd_prev;
                end
                else
                begin
                    prev_we = 1'b1;
                    prev_wa = rd_next;
                    prev_wd = rd_prev;
                end
                cur_next[lix] = (rd_next != NIL) ? rd_next : rd_prev;
                pos_next[lix] = POS_ON;
                if (size_reg[lix] != '0)
                begin
                    size_next[lix] = size_reg[lix] - NW'(1);
                end
                stk_we      = 1'b1;
                rc_cnt_next = rc_cnt_reg + NW'(1);
            end
            ST_CONCAT:
            begin
                // view points at the second list here
                if (v_size != '0)
                begin
                    if (walk_cnt_reg == '0)
                    begin
                        head_next[lix] = v_head;
                        tail_next[lix] = v_tail;
                        cur_next[lix]  = v_cur;
                        pos_next[lix]  = v_pos;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = a_reg;
                        next_wd = v_head;
                        prev_we = 1'b1;
                        prev_wa = v_head;
                        prev_wd = a_reg;
                        tail_next[lix] = v_tail;
                    end
                    size_next[lix] = walk_cnt_reg + v_size;
                end
                rel_en  = 1'b1;
                rel_idx = mix;
            end
            ST_WALK:
            begin
                // push one node a cycle, follow its next link
                stk_we        = 1'b1;
                rc_cnt_next   = rc_cnt_reg + NW'(1);
                walk_cnt_next = walk_cnt_reg - NW'(1);
                if (walk_cnt_reg == NW'(1) || rd_next == NIL)
                begin
                    rel_en = 1'b1;
                end
                else
                begin
                    n_next = rd_next;
                    rd_en  = 1'b1;
                    rd_ptr = rd_next;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_item_next   = res_item_reg;
                    out_new_next    = res_new_reg;
                    out_count_next  = l_ok ? COUNT_W'(size_reg[lix]) : '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase

        if (new_en)
        begin
            head_next[new_idx] = NIL;
            tail_next[new_idx] = NIL;
            cur_next[new_idx]  = NIL;
            pos_next[new_idx]  = POS_ON;
            size_next[new_idx] = '0;
            used_next[new_idx] = 1'b1;
        end
        if (rel_en)
        begin
            head_next[rel_idx] = NIL;
            tail_next[rel_idx] = NIL;
            cur_next[rel_idx]  = NIL;
            pos_next[rel_idx]  = POS_ON;
            size_next[rel_idx] = '0;
            used_next[rel_idx] = 1'b0;
            fl_stack_next[LW'(fl_cnt_reg)] = rel_idx;
            fl_cnt_next = fl_cnt_reg + LCW'(1);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rc_cnt_reg    <= '0;
            fresh_reg     <= '0;
            fl_cnt_reg    <= LCW'(LIST_COUNT);
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_reg[i]     <= NIL;
                tail_reg[i]     <= NIL;
                cur_reg[i]      <= NIL;
                pos_reg[i]      <= POS_ON;
                size_reg[i]     <= '0;
                used_reg[i]     <= 1'b0;
                fl_stack_reg[i] <= LW'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rc_cnt_reg    <= rc_cnt_next;
            fresh_reg     <= fresh_next;
            fl_cnt_reg    <= fl_cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            size_reg      <= size_next;
            used_reg      <= used_next;
            fl_stack_reg  <= fl_stack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        lid_reg        <= lid_next;
        mid_reg        <= mid_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
        res_new_reg    <= res_new_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        n_reg          <= n_next;
        walk_cnt_reg   <= walk_cnt_next;
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_new_reg    <= out_new_next;
        out_count_reg  <= out_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - ITEM_W - LID_W - COUNT_W){1'b0}},
                       out_count_reg, out_new_reg, out_item_reg};

endmodule
`default_nettype wire

FILE: sv/pdll_checker.sv
// Port-level checks for the pooled doubly linked list engine, bound to its top level.
// Depends on pdll_pkg.
`default_nettype none
module pdll_checker
    import pdll_pkg::*;
#(
    parameter int NODE_COUNT = 128
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0]  m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time: drop ready after a request
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

    a_noitem: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata[31:0] == '0 && m_tdata[35:32] == '0)
        else $error("failed request returned an item or handle");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[43:36] <= COUNT_W'(NODE_COUNT))
        else $error("count beyond node pool");

endmodule

bind pooled_doubly_linked_list_engine_unit pdll_checker #(.NODE_COUNT(NODE_COUNT)) u_pdll_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the pooled doubly linked list engine: directed table then random
// request mix; results checked against typed table rows or an in-bench list pool predictor.
// Depends on pdll_pkg and pooled_doubly_linked_list_engine_unit.
`timescale 1ns / 1ps
module tb_top;
    import pdll_pkg::*;

    localparam int NODES = 128;
    localparam int LISTS = 16;
    localparam int NIL = NODES;
    localparam int RANDOM_REQUESTS = 650;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_START = 2000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        status_t     st;
        logic [31:0] item;
        logic [3:0]  nid;
        logic [7:0]  cnt;
    } result_t;

    typedef struct packed {
        logic [3:0]  k;
        logic [3:0]  l;
        logic [3:0]  o;
        logic [31:0] it;
        bit          typed;
        result_t     r;
    } row_t;

    localparam int PLAN_LEN = 25;
    localparam row_t PLAN [PLAN_LEN] = '{
        '{KIND_COUNT,   4'd0,  4'd0,  32'h0,        1'b1, '{STATUS_BAD, 32'h0, 4'd0, 8'd0}},
        '{4'd15,        4'd0,  4'd0,  32'h0,        1'b1, '{STATUS_BAD, 32'h0, 4'd0, 8'd0}},
        '{KIND_CREATE,  4'd0,  4'd0,  32'h0,        1'b1, '{STATUS_OK, 32'h0, 4'd15, 8'd0}},
        '{KIND_APPEND,  4'd15, 4'd0,  32'h0,        1'b1, '{STATUS_BAD, 32'h0, 4'd0, 8'd0}},
        '{KIND_CURRENT, 4'd15, 4'd0,  32'h0,        1'b1, '{STATUS_NONE, 32'h0, 4'd0, 8'd0}},
        '{KIND_APPEND,  4'd15, 4'd0,  32'hFFFFFFFF, 1'b1, '{STATUS_OK, 32'h0, 4'd0, 8'd1}},
        '{KIND_FIRST,   4'd15, 4'd0,  32'h0,        1'b1,
          '{STATUS_OK, 32'hFFFFFFFF, 4'd0, 8'd1}},
        '{KIND_LAST,    4'd15, 4'd0,  32'h0,        1'b1,
          '{STATUS_OK, 32'hFFFFFFFF, 4'd0, 8'd1}},
        '{KIND_PREPEND, 4'd15, 4'd0,  32'h1,        1'b0, '0},
        '{KIND_INSERT,  4'd15, 4'd0,  32'h80000000, 1'b0, '0},
        '{KIND_ADD,     4'd15, 4'd0,  32'h5A5A5A5A, 1'b0, '0},
        '{KIND_NEXT,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_NEXT,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_NEXT,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_PREV,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_FIRST,   4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_PREV,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_ADD,     4'd15, 4'd0,  32'hA5A5A5A5, 1'b0, '0},
        '{KIND_REMOVE,  4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_TRIM,    4'd15, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_CREATE,  4'd0,  4'd0,  32'h0,        1'b1, '{STATUS_OK, 32'h0, 4'd14, 8'd0}},
        '{KIND_CONCAT,  4'd14, 4'd15, 32'h0,        1'b0, '0},
        '{KIND_CONCAT,  4'd14, 4'd14, 32'h0,        1'b0, '0},
        '{KIND_FREE,    4'd14, 4'd0,  32'h0,        1'b0, '0},
        '{KIND_COUNT,   4'd14, 4'd0,  32'h0,        1'b1, '{STATUS_BAD, 32'h0, 4'd0, 8'd0}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [LID_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    pooled_doubly_linked_list_engine_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // list pool mirror
    logic [31:0] node_val [NODES+1];
    int          node_nx [NODES+1];
    int          node_pv [NODES+1];
    int          spare_nodes [NODES];
    int          spare_node_cnt;
    int          head [LISTS];
    int          tail [LISTS];
    int          cursor [LISTS];
    pos_t        cpos [LISTS];
    int          size [LISTS];
    bit          in_use [LISTS];
    int          spare_lists [LISTS];
    int          spare_list_cnt;

    result_t     pending [$];
    int          errors = 0;
    int          cycles = 0;

    function automatic int nd(int n);
        return n < NODES ? n : NIL;
    endfunction

    function automatic void empty_list(int l);
        head[l] = NIL;
        tail[l] = NIL;
        cursor[l] = NIL;
        cpos[l] = POS_ON;
        size[l] = 0;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i <= NODES; i++)
        begin
            node_val[i] = '0;
            node_nx[i] = 0;
            node_pv[i] = 0;
        end
        for (int i = 0; i < NODES; i++)
            spare_nodes[i] = i;
        spare_node_cnt = NODES;
        for (int i = 0; i < LISTS; i++)
        begin
            empty_list(i);
            in_use[i] = 1'b0;
            spare_lists[i] = i;
        end
        spare_list_cnt = LISTS;
    endfunction

    function automatic void return_node(int n);
        if (n < NODES && spare_node_cnt < NODES)
        begin
            spare_nodes[spare_node_cnt] = n;
            spare_node_cnt++;
        end
    endfunction

    function automatic void drop_list(int l);
        empty_list(l);
        in_use[l] = 1'b0;
        if (spare_list_cnt < LISTS)
        begin
            spare_lists[spare_list_cnt] = l;
            spare_list_cnt++;
        end
    endfunction

    function automatic void splice_in(int l, int pre, int post, logic [31:0] it);
        int n;
        spare_node_cnt--;
        n = nd(spare_nodes[spare_node_cnt]);
        node_val[n] = it;
        node_pv[n] = pre;
        node_nx[n] = post;
        if (pre == NIL) head[l] = n; else node_nx[nd(pre)] = n;
        if (post == NIL) tail[l] = n; else node_pv[nd(post)] = n;
        cursor[l] = n;
        cpos[l] = POS_ON;
        size[l]++;
    endfunction

    function automatic logic [31:0] splice_out(int l, int c);
        int pre;
        int post;
        logic [31:0] it;
        c = nd(c);
        it = node_val[c];
        pre = nd(node_pv[c]);
        post = nd(node_nx[c]);
        if (pre == NIL) head[l] = post; else node_nx[pre] = post;
        if (post == NIL) tail[l] = pre; else node_pv[post] = pre;
        cursor[l] = (post != NIL) ? post : pre;
        cpos[l] = POS_ON;
        if (size[l] > 0) size[l]--;
        return_node(c);
        return it;
    endfunction

    function automatic result_t list_op(logic [3:0] k, int l, int m, logic [31:0] it);
        result_t r;
        bit ok;
        bit emp;
        int cur;
        int pre;
        int post;
        int n;
        int nx;
        int sz;
        int id;
        r = '{STATUS_OK, 32'h0, 4'd0, 8'd0};
        ok = in_use[l];
        emp = ok ? (size[l] == 0) : 1'b1;
        cur = cursor[l];
        pre = NIL;
        post = NIL;
        if (k == KIND_CREATE)
        begin
            if (spare_list_cnt == 0)
                r.st = STATUS_LIST_FULL;
            else
            begin
                spare_list_cnt--;
                id = spare_lists[spare_list_cnt];
                empty_list(id);
                in_use[id] = 1'b1;
                r.nid = id[3:0];
            end
        end
        else if (k > KIND_FREE || !ok)
            r.st = STATUS_BAD;
        else if (k == KIND_COUNT)
            r.st = STATUS_OK;
        else if (k == KIND_FIRST || k == KIND_LAST)
        begin
            if (emp)
                r.st = STATUS_NONE;
            else
            begin
                cursor[l] = (k == KIND_FIRST) ? head[l] : tail[l];
                cpos[l] = POS_ON;
                r.item = node_val[nd(cursor[l])];
            end
        end
        else if (k == KIND_NEXT)
        begin
            if (emp || cpos[l] == POS_PAST || (cpos[l] == POS_ON && cur == tail[l]))
            begin
                cursor[l] = NIL;
                cpos[l] = POS_PAST;
                r.st = STATUS_NONE;
            end
            else
            begin
                cursor[l] = (cpos[l] == POS_BEFORE) ? head[l] : nd(node_nx[nd(cur)]);
                cpos[l] = POS_ON;
                r.item = node_val[nd(cursor[l])];
            end
        end
        else if (k == KIND_PREV)
        begin
            if (emp || cpos[l] == POS_BEFORE || (cpos[l] == POS_ON && cur == head[l]))
            begin
                cursor[l] = NIL;
                cpos[l] = POS_BEFORE;
                r.st = STATUS_NONE;
            end
            else
            begin
                cursor[l] = (cpos[l] == POS_PAST) ? tail[l] : nd(node_pv[nd(cur)]);
                cpos[l] = POS_ON;
                r.item = node_val[nd(cursor[l])];
            end
        end
        else if (k == KIND_CURRENT)
        begin
            if (emp || cpos[l] != POS_ON) r.st = STATUS_NONE;
            else r.item = node_val[nd(cur)];
        end
        else if (k >= KIND_ADD && k <= KIND_PREPEND)
        begin
            if (it == 0)
                r.st = STATUS_BAD;
            else if (spare_node_cnt == 0)
                r.st = STATUS_NODE_FULL;
            else
            begin
                if (emp)
                    ;
                else if (k == KIND_APPEND)
                    pre = tail[l];
                else if (k == KIND_PREPEND)
                    post = head[l];
                else if (k == KIND_ADD)
                begin
                    if (cpos[l] == POS_BEFORE) post = head[l];
                    else if (cpos[l] == POS_PAST || cur == tail[l]) pre = tail[l];
                    else
                    begin
                        pre = cur;
                        post = nd(node_nx[nd(cur)]);
                    end
                end
                else
                begin
                    if (cpos[l] == POS_BEFORE || (cpos[l] == POS_ON && cur == head[l]))
                        post = head[l];
                    else if (cpos[l] == POS_PAST) pre = tail[l];
                    else
                    begin
                        pre = nd(node_pv[nd(cur)]);
                        post = cur;
                    end
                end
                splice_in(l, pre, post, it);
            end
        end
        else if (k == KIND_REMOVE)
        begin
            if (emp || cpos[l] != POS_ON) r.st = STATUS_NONE;
            else r.item = splice_out(l, cur);
        end
        else if (k == KIND_TRIM)
        begin
            if (emp) r.st = STATUS_NONE;
            else r.item = splice_out(l, tail[l]);
        end
        else if (k == KIND_CONCAT)
        begin
            if (m == l || !in_use[m])
                r.st = STATUS_BAD;
            else
            begin
                if (size[m] > 0)
                begin
                    if (emp)
                    begin
                        head[l] = head[m];
                        tail[l] = tail[m];
                        cursor[l] = cursor[m];
                        cpos[l] = cpos[m];
                    end
                    else
                    begin
                        node_nx[nd(tail[l])] = head[m];
                        node_pv[nd(head[m])] = tail[l];
                        tail[l] = tail[m];
                    end
                    size[l] = size[l] + size[m];
                end
                drop_list(m);
            end
        end
        else
        begin
            n = head[l];
            sz = size[l];
            for (int i = 0; i < sz && n != NIL; i++)
            begin
                nx = nd(node_nx[nd(n)]);
                return_node(n);
                n = nx;
            end
            drop_list(l);
        end
        r.cnt = in_use[l] ? size[l][7:0] : 8'd0;
        return r;
    endfunction

    // predict at issue time, then hold the request until the engine takes it
    task automatic issue(logic [3:0] k, logic [3:0] l, logic [3:0] o, logic [31:0] it,
                         bit typed = 1'b0, result_t typed_r = '0);
        result_t r;
        int gap;
        r = list_op(k, l, o, it);
        pending.push_back(typed ? typed_r : r);
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {it, o, l};
        do @(posedge clk); while (!s_tready);
        // bursts: mostly back to back, sometimes a gap
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [3:0] pick_list();
        int used [$];
        for (int i = 0; i < LISTS; i++)
            if (in_use[i]) used.push_back(i);
        if (used.size() == 0 || $urandom_range(0, 9) == 0)
            return 4'($urandom_range(0, 15));
        return 4'(used[$urandom_range(0, used.size() - 1)]);
    endfunction

    function automatic logic [31:0] pick_item();
        case ($urandom_range(0, 19))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_request();
        int w;
        int used;
        logic [3:0] l;
        logic [3:0] k;
        used = LISTS - spare_list_cnt;
        l = pick_list();
        w = $urandom_range(0, 99);
        if (used < 3 && w < 40) k = KIND_CREATE;
        else if (w < 3) k = KIND_CREATE;
        else if (w < 30) k = 4'($urandom_range(KIND_ADD, KIND_PREPEND));
        else if (w < 62) k = 4'($urandom_range(KIND_COUNT, KIND_CURRENT));
        else if (w < 80) k = 4'($urandom_range(KIND_REMOVE, KIND_TRIM));
        else if (w < 88) k = KIND_CONCAT;
        else if (w < 93) k = KIND_FREE;
        else if (w < 95) k = 4'd15;
        else k = KIND_APPEND;
        issue(k, l, (k == KIND_CONCAT) ? pick_list() : 4'($urandom_range(0, 15)),
              pick_item());
    endtask

    // fill the node pool until it refuses, then release everything
    task automatic exhaust_nodes();
        logic [3:0] l;
        while (spare_list_cnt == 0)
            issue(KIND_FREE, pick_list(), 4'd0, 32'h0);
        l = 4'(spare_lists[spare_list_cnt - 1]);
        issue(KIND_CREATE, 4'd0, 4'd0, 32'h0);
        while (spare_node_cnt > 0)
            issue(KIND_APPEND, l, 4'd0, $urandom() | 32'h1);
        issue(KIND_PREPEND, l, 4'd0, 32'h12345678);
        for (int i = 0; i < LISTS; i++)
            if (in_use[i]) issue(KIND_FREE, 4'(i), 4'd0, 32'h0);
    endtask

    task automatic exhaust_lists();
        while (spare_list_cnt > 0)
            issue(KIND_CREATE, 4'd0, 4'd0, 32'h0);
        issue(KIND_CREATE, 4'd0, 4'd0, 32'h0);
        for (int i = 0; i < LISTS; i += 2)
            issue(KIND_FREE, 4'(i), 4'd0, 32'h0);
    endtask

    // result side: own ready pattern plus one long hold-off
    int rx_mode = 0;
    int rx_cycles = 0;
    always @(posedge clk)
    begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 256 == 0)
            rx_mode <= $urandom_range(0, 2);
        if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
            m_tready <= 1'b0;
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (m_tuser !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== want.item)
                begin
                    $error("item_out: expected %h, got %h", want.item, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[35:32] !== want.nid)
                begin
                    $error("new_list_id: expected %0d, got %0d", want.nid, m_tdata[35:32]);
                    errors++;
                end
                if (m_tdata[43:36] !== want.cnt)
                begin
                    $error("count_out: expected %0d, got %0d", want.cnt, m_tdata[43:36]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        pool_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        foreach (PLAN[i])
            issue(PLAN[i].k, PLAN[i].l, PLAN[i].o, PLAN[i].it, PLAN[i].typed, PLAN[i].r);
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 300) exhaust_nodes();
            if (n == 600) exhaust_lists();
            random_request();
        end
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/pdll_pkg.sv
sv/pooled_doubly_linked_list_engine_unit.sv
sv/pdll_checker.sv
bench/tb_top.sv
